// ===== rtl/pli_pkg.sv =====
`default_nettype none
package pli_pkg;

    localparam int POINTS  = 1024;
    localparam int IDX_W   = $clog2(POINTS);
    localparam int CNT_W   = 11;
    localparam int DIVD_W  = 49;
    localparam int DIVS_W  = 33;
    localparam int PROD_W  = DIVD_W + DIVS_W;
    localparam int STEP_W  = 6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NO_BRKT = 2'd1;
    localparam logic [1:0] ST_ZERO_DX = 2'd2;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [9:0]  point_index;
        logic [31:0] point_x;
        logic [31:0] point_y;
        logic [31:0] query_x;
        logic        last_query;
    } req_t;

    typedef struct packed {
        logic [31:0] interp_value;
        logic [1:0]  status;
        logic        last_result;
    } res_t;

endpackage
`default_nettype wire

// ===== rtl/pli_ram.sv =====
`default_nettype none
module pli_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/pli_div.sv =====
`default_nettype none
// Restoring divider on magnitudes, one quotient bit a cycle.
module pli_div (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pli_pkg::DIVD_W-1:0]  dividend,
    input  wire logic [pli_pkg::DIVS_W-1:0]  divisor,
    output logic                             done,
    output logic      [pli_pkg::DIVD_W-1:0]  quotient
);

    logic [pli_pkg::DIVS_W-1:0] rem_reg, rem_next;
    logic [pli_pkg::DIVD_W-1:0] quo_reg, quo_next;
    logic [pli_pkg::DIVS_W-1:0] dvs_reg, dvs_next;
    logic [pli_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;
    logic [pli_pkg::DIVS_W:0]   rem_sh;
    logic [pli_pkg::DIVS_W:0]   trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_sh    = {rem_reg, quo_reg[pli_pkg::DIVD_W-1]};
        trial     = rem_sh - {1'b0, dvs_reg};
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[pli_pkg::DIVS_W])
            begin
                rem_next = trial[pli_pkg::DIVS_W-1:0];
                quo_next = {quo_reg[pli_pkg::DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[pli_pkg::DIVS_W-1:0];
                quo_next = {quo_reg[pli_pkg::DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pli_pkg::STEP_W'(pli_pkg::DIVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

// ===== rtl/pli_mul.sv =====
`default_nettype none
// Shift-and-add multiplier on magnitudes, one multiplier bit a cycle.
module pli_mul (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [pli_pkg::DIVS_W-1:0]  mcand,
    input  wire logic [pli_pkg::DIVD_W-1:0]  mplier,
    output logic                             done,
    output logic      [pli_pkg::PROD_W-1:0]  product
);

    logic [pli_pkg::PROD_W-1:0] acc_reg, acc_next;
    logic [pli_pkg::PROD_W-1:0] mc_reg, mc_next;
    logic [pli_pkg::DIVD_W-1:0] mp_reg, mp_next;
    logic [pli_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                       run_reg, run_next;
    logic                       done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        mc_next   = mc_reg;
        mp_next   = mp_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next = '0;
            mc_next  = pli_pkg::PROD_W'(mcand);
            mp_next  = mplier;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (mp_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = {mc_reg[pli_pkg::PROD_W-2:0], 1'b0};
            mp_next  = {1'b0, mp_reg[pli_pkg::DIVD_W-1:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == pli_pkg::STEP_W'(pli_pkg::DIVD_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        mc_reg  <= mc_next;
        mp_reg  <= mp_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/piecewise_linear_interpolator_core.sv =====
`default_nettype none
// Piecewise linear interpolation over a table of up to 1024 Q16.16 points.
// Request channel: start/busy. A request is taken at a clock edge with start
// high and busy low. A load request (cmd 0) writes x and y into the slot in
// the same cycle and never raises busy. A query request (cmd 1) raises busy
// until its result has been issued, unless fewer than two points are in use.
// Result channel: result_valid is a one-cycle strobe; result is valid only in
// that cycle. The receiver cannot stall, so nothing is held back.
// Configuration: cfg_data (points in use) is written when cfg_valid and
// cfg_ready are high; cfg_ready is always high. Write it only while idle.
// Query flow: a linear scan of the x memory (one entry a cycle), then a
// serial divide for mu and a serial multiply for the blend.
// A query that misses every point gives a no-bracket result; fewer than two points
// in use gives a result in the cycle after the request.
// Reset clears the controller and the point count; the table memories are
// not cleared and must be loaded before they are searched.
module piecewise_linear_interpolator_core (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire pli_pkg::req_t        req,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [10:0]          cfg_data,
    output logic                      result_valid,
    output pli_pkg::res_t             result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_YA   = 3'd2;
    localparam logic [2:0] S_YB   = 3'd3;
    localparam logic [2:0] S_YC   = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_MUL  = 3'd6;

    logic [2:0]                      state_reg, state_next;
    logic [pli_pkg::CNT_W-1:0]       npts_reg;
    logic [pli_pkg::CNT_W-1:0]       n;
    logic [pli_pkg::CNT_W-1:0]       addr_reg, addr_next;
    logic [pli_pkg::CNT_W-1:0]       ridx_reg, ridx_next;
    logic                            rvld_reg, rvld_next;
    logic [pli_pkg::IDX_W-1:0]       j_reg, j_next;
    logic [31:0]                     q_reg, q_next;
    logic                            last_reg, last_next;
    logic [31:0]                     prev_x_reg, prev_x_next;
    logic [31:0]                     x0_reg, x0_next;
    logic [31:0]                     x1_reg, x1_next;
    logic [31:0]                     y0_reg, y0_next;
    logic [pli_pkg::DIVS_W-1:0]      mdy_reg, mdy_next;
    logic                            dy_neg_reg, dy_neg_next;
    logic                            mu_neg_reg, mu_neg_next;
    logic                            res_vld_reg, res_vld_next;
    pli_pkg::res_t                   res_reg, res_next;

    logic                            accept;
    logic                            load_we;
    logic [pli_pkg::IDX_W-1:0]       y_raddr;
    logic [31:0]                     x_rdata;
    logic [31:0]                     y_rdata;

    logic signed [pli_pkg::DIVS_W-1:0] dx;
    logic signed [pli_pkg::DIVS_W-1:0] dq;
    logic signed [pli_pkg::DIVS_W-1:0] dy;
    logic signed [pli_pkg::DIVD_W-1:0] num;
    logic [pli_pkg::DIVD_W-1:0]        mnum;
    logic [pli_pkg::DIVS_W-1:0]        mdx;
    logic                              div_start;
    logic                              div_done;
    logic [pli_pkg::DIVD_W-1:0]        div_quo;
    logic                              mul_start;
    logic                              mul_done;
    logic [pli_pkg::PROD_W-1:0]        mul_prod;
    logic                              prod_sat;
    logic [33:0]                       step;
    logic signed [34:0]                sum;
    logic [31:0]                       blend_val;

    // Clamp the point count to the table size
    assign n = (npts_reg > pli_pkg::CNT_W'(pli_pkg::POINTS))
             ? pli_pkg::CNT_W'(pli_pkg::POINTS) : npts_reg;

    assign busy      = (state_reg != S_IDLE);
    assign accept    = start && !busy;
    assign load_we   = accept && (req.cmd == pli_pkg::CMD_LOAD);
    assign cfg_ready = 1'b1;
    assign y_raddr   = (state_reg == S_YA) ? (j_reg - 1'b1) : j_reg;

    pli_ram #(.WIDTH(32), .DEPTH(pli_pkg::POINTS)) u_x_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (req.point_index),
        .wdata (req.point_x),
        .raddr (addr_reg[pli_pkg::IDX_W-1:0]),
        .rdata (x_rdata)
    );

    pli_ram #(.WIDTH(32), .DEPTH(pli_pkg::POINTS)) u_y_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (req.point_index),
        .wdata (req.point_y),
        .raddr (y_raddr),
        .rdata (y_rdata)
    );

    // Segment arithmetic: widths grow by one bit so nothing wraps
    assign dx   = $signed({x1_reg[31], x1_reg}) - $signed({x0_reg[31], x0_reg});
    assign dq   = $signed({q_reg[31], q_reg}) - $signed({x0_reg[31], x0_reg});
    assign num  = {dq, 16'h0000};
    assign mnum = num[pli_pkg::DIVD_W-1] ? (~num + 1'b1) : num;
    assign mdx  = dx[pli_pkg::DIVS_W-1] ? (~dx + 1'b1) : dx;
    assign dy   = $signed({y_rdata[31], y_rdata}) - $signed({y0_reg[31], y0_reg});

    pli_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mnum),
        .divisor  (mdx),
        .done     (div_done),
        .quotient (div_quo)
    );

    pli_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mdy_reg),
        .mplier  (div_quo),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Blend: saturate once |dy|*|mu| passes 2^49, otherwise add the signed step to y0
    assign prod_sat = (mul_prod > (pli_pkg::PROD_W'(1) << 49));
    assign step     = mul_prod[49:16];
    assign sum      = (dy_neg_reg ^ mu_neg_reg)
                    ? ($signed({{3{y0_reg[31]}}, y0_reg}) - $signed({1'b0, step}))
                    : ($signed({{3{y0_reg[31]}}, y0_reg}) + $signed({1'b0, step}));

    always_comb
    begin
        if (prod_sat)
        begin
            blend_val = (dy_neg_reg ^ mu_neg_reg) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else if (sum[34:31] == 4'b0000 || sum[34:31] == 4'b1111)
        begin
            blend_val = sum[31:0];
        end
        else
        begin
            blend_val = sum[34] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        addr_next    = addr_reg;
        ridx_next    = ridx_reg;
        rvld_next    = rvld_reg;
        j_next       = j_reg;
        q_next       = q_reg;
        last_next    = last_reg;
        prev_x_next  = prev_x_reg;
        x0_next      = x0_reg;
        x1_next      = x1_reg;
        y0_next      = y0_reg;
        mdy_next     = mdy_reg;
        dy_neg_next  = dy_neg_reg;
        mu_neg_next  = mu_neg_reg;
        res_vld_next = 1'b0;
        res_next     = res_reg;
        div_start    = 1'b0;
        mul_start    = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && req.cmd == pli_pkg::CMD_QUERY)
                begin
                    q_next    = req.query_x;
                    last_next = req.last_query;
                    addr_next = '0;
                    rvld_next = 1'b0;
                    if (n < pli_pkg::CNT_W'(2))
                    begin
                        res_vld_next          = 1'b1;
                        res_next.interp_value = '0;
                        res_next.status       = pli_pkg::ST_NO_BRKT;
                        res_next.last_result  = req.last_query;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                // Issue one x read a cycle; the data for ridx arrives in the next cycle
                if (addr_reg < n)
                begin
                    addr_next = addr_reg + 1'b1;
                    rvld_next = 1'b1;
                    ridx_next = addr_reg;
                end
                else
                begin
                    rvld_next = 1'b0;
                end
                if (rvld_reg)
                begin
                    if (ridx_reg == '0)
                    begin
                        prev_x_next = x_rdata;
                    end
                    else if ($signed(x_rdata) >= $signed(q_reg))
                    begin
                        x0_next    = prev_x_reg;
                        x1_next    = x_rdata;
                        j_next     = ridx_reg[pli_pkg::IDX_W-1:0];
                        state_next = S_YA;
                    end
                    else
                    begin
                        prev_x_next = x_rdata;
                        if (ridx_reg == n - 1'b1)
                        begin
                            res_vld_next          = 1'b1;
                            res_next.interp_value = '0;
                            res_next.status       = pli_pkg::ST_NO_BRKT;
                            res_next.last_result  = last_reg;
                            state_next            = S_IDLE;
                        end
                    end
                end
            end
            S_YA:
            begin
                state_next = S_YB;
            end
            S_YB:
            begin
                y0_next    = y_rdata;
                state_next = S_YC;
            end
            S_YC:
            begin
                if (dx == '0)
                begin
                    res_vld_next          = 1'b1;
                    res_next.interp_value = '0;
                    res_next.status       = pli_pkg::ST_ZERO_DX;
                    res_next.last_result  = last_reg;
                    state_next            = S_IDLE;
                end
                else
                begin
                    mdy_next    = dy[pli_pkg::DIVS_W-1] ? (~dy + 1'b1) : dy;
                    dy_neg_next = dy[pli_pkg::DIVS_W-1];
                    mu_neg_next = num[pli_pkg::DIVD_W-1] ^ dx[pli_pkg::DIVS_W-1];
                    div_start   = 1'b1;
                    state_next  = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    mul_start  = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_done)
                begin
                    res_vld_next          = 1'b1;
                    res_next.interp_value = blend_val;
                    res_next.status       = pli_pkg::ST_OK;
                    res_next.last_result  = last_reg;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            npts_reg    <= '0;
            rvld_reg    <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rvld_reg    <= rvld_next;
            res_vld_reg <= res_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                npts_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg   <= addr_next;
        ridx_reg   <= ridx_next;
        j_reg      <= j_next;
        q_reg      <= q_next;
        last_reg   <= last_next;
        prev_x_reg <= prev_x_next;
        x0_reg     <= x0_next;
        x1_reg     <= x1_next;
        y0_reg     <= y0_next;
        mdy_reg    <= mdy_next;
        dy_neg_reg <= dy_neg_next;
        mu_neg_reg <= mu_neg_next;
        res_reg    <= res_next;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

endmodule
`default_nettype wire

// ===== dv/pli_interp_checker.sv =====
`default_nettype none
module pli_interp_checker (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic          busy,
    input  wire pli_pkg::req_t req,
    input  wire logic          cfg_valid,
    input  wire logic          cfg_ready,
    input  wire logic [10:0]   cfg_data,
    input  wire logic          result_valid,
    input  wire pli_pkg::res_t result,
    output int                 errors,
    output int                 pending
);
    timeunit 1ns;
    timeprecision 1ps;

    int            x_tab [pli_pkg::POINTS];
    int            y_tab [pli_pkg::POINTS];
    logic [10:0]   span;
    pli_pkg::res_t interp_due [$];

    // Saturating blend y0 + (y1 - y0) * mu, mu in Q16.16.
    function automatic int blend_q16(int y0, int y1, longint mu);
        longint          dy;
        longint unsigned mdy;
        longint unsigned mmu;
        longint unsigned step;
        longint          sum;
        bit              neg;
        dy  = longint'(y1) - longint'(y0);
        mdy = (dy < 0) ? -dy : dy;
        mmu = (mu < 0) ? -mu : mu;
        neg = (dy < 0) != (mu < 0);
        if (mdy == 0 || mmu == 0)
            return y0;
        if (mdy > (64'd1 << 49) / mmu)
            return neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        step = (mdy * mmu) >> 16;
        sum  = longint'(y0) + (neg ? -longint'(step) : longint'(step));
        if (sum > 64'sd2147483647)
            return 32'sh7fff_ffff;
        if (sum < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(sum);
    endfunction

    function automatic pli_pkg::res_t predict_interp(int q, logic last);
        pli_pkg::res_t r;
        int            n;
        longint        dx;
        longint        mu;
        n = (span > pli_pkg::POINTS) ? pli_pkg::POINTS : int'(span);
        r.interp_value = '0;
        r.status       = pli_pkg::ST_NO_BRKT;
        r.last_result  = last;
        for (int j = 1; j < n; j++)
        begin
            if (x_tab[j] >= q)
            begin
                dx = longint'(x_tab[j]) - longint'(x_tab[j-1]);
                if (dx == 0)
                begin
                    r.status = pli_pkg::ST_ZERO_DX;
                end
                else
                begin
                    mu = ((longint'(q) - longint'(x_tab[j-1])) * 65536) / dx;
                    r.interp_value = blend_q16(y_tab[j-1], y_tab[j], mu);
                    r.status       = pli_pkg::ST_OK;
                end
                break;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pli_pkg::res_t want;
        if (!rst_n)
        begin
            span = '0;
            interp_due.delete();
            pending = 0;
            errors  = 0;
        end
        else
        begin
            // Compare first: a result on this edge belongs to an older request.
            if (result_valid)
            begin
                if (interp_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, result);
                end
                else
                begin
                    want = interp_due.pop_front();
                    if (result.interp_value !== want.interp_value)
                    begin
                        errors++;
                        $display("%0t: interp_value expected %h actual %h", $time,
                                 want.interp_value, result.interp_value);
                    end
                    if (result.status !== want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time,
                                 want.status, result.status);
                    end
                    if (result.last_result !== want.last_result)
                    begin
                        errors++;
                        $display("%0t: last_result expected %b actual %b", $time,
                                 want.last_result, result.last_result);
                    end
                end
            end
            if (start && !busy)
            begin
                if (req.cmd == pli_pkg::CMD_LOAD)
                begin
                    x_tab[req.point_index] = int'(req.point_x);
                    y_tab[req.point_index] = int'(req.point_y);
                end
                else
                begin
                    interp_due.insert(interp_due.size(),
                                      predict_interp(int'(req.query_x), req.last_query));
                end
            end
            if (cfg_valid && cfg_ready)
                span = cfg_data;
            pending = interp_due.size();
        end
    end
endmodule
`default_nettype wire

// ===== dv/tb_piecewise_linear_interpolator_core.sv =====
`default_nettype none
module tb_piecewise_linear_interpolator_core;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous: queries on large tables take long, as the scan is linear.
    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int RANDOM_REQS = 540;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          start;
    logic          busy;
    pli_pkg::req_t req;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [10:0]   cfg_data;
    logic          result_valid;
    pli_pkg::res_t result;
    int            errors;
    int            pending;
    int            cycles = 0;
    bit            calm;       // no idling in this stretch
    int            seg_x [$];  // abscissae of the current small table

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    piecewise_linear_interpolator_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    pli_interp_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result),
        .errors       (errors),
        .pending      (pending)
    );

    // Abort a hung run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Load request; the unused query fields carry noise.
    function automatic pli_pkg::req_t load_req(int idx, int x, int y);
        pli_pkg::req_t r;
        r.cmd         = pli_pkg::CMD_LOAD;
        r.point_index = idx[9:0];
        r.point_x     = x;
        r.point_y     = y;
        r.query_x     = $urandom;
        r.last_query  = $urandom_range(0, 1);
        return r;
    endfunction

    // Query request; the unused load fields carry noise.
    function automatic pli_pkg::req_t query_req(int q, logic last);
        pli_pkg::req_t r;
        r.cmd         = pli_pkg::CMD_QUERY;
        r.point_index = $urandom_range(0, 1023);
        r.point_x     = $urandom;
        r.point_y     = $urandom;
        r.query_x     = q;
        r.last_query  = last;
        return r;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 19);
        if (calm || r < 10)
            return 0;
        if (r < 18)
            return $urandom_range(1, 3);
        return $urandom_range(20, 60);
    endfunction

    // Call at a rising edge; return at the edge that takes the request.
    // Busy only moves on rising edges, so sample it on the falling one.
    task automatic issue(input pli_pkg::req_t item);
        start <= 1'b1;
        req   <= item;
        do @(negedge clk); while (busy);
        @(posedge clk);
    endtask

    task automatic rest(input int n);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Hold off until every result is in, then let the block settle.
    task automatic drain();
        start <= 1'b0;
        do @(negedge clk); while (pending != 0);
        @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_span(input int n);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= n[10:0];
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Query near the small table's points, or anywhere.
    function automatic int pick_query();
        int r;
        r = $urandom_range(0, 9);
        if (seg_x.size() == 0 || r < 2)
            return $urandom;
        if (r < 4)
            return seg_x[$urandom_range(0, seg_x.size() - 1)];
        return seg_x[$urandom_range(0, seg_x.size() - 1)]
               + int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endfunction

    // Load a fresh table of n points: sorted mostly, unsorted sometimes.
    task automatic load_table(input int n, inout int count);
        int style;
        int v;
        int ys;
        style = $urandom_range(0, 9);
        ys    = $urandom_range(0, 2);
        seg_x.delete();
        for (int i = 0; i < n; i++)
        begin
            if (style < 3)
                v = $urandom;
            else if (style < 7)
                v = (int'($urandom_range(0, 40)) - 20) <<< 14;  // collisions likely
            else
                v = int'($urandom_range(0, 30000)) * 65536 - 32'sd983040000;
            seg_x.insert(seg_x.size(), v);
        end
        if (style != 9)
            seg_x.sort();
        for (int i = 0; i < n; i++)
        begin
            v = (ys == 0) ? int'($urandom) : int'($urandom_range(0, 1 << 22)) - (1 << 21);
            issue(load_req(i, seg_x[i], v));
            count++;
            rest(gap_len());
        end
    endtask

    initial
    begin
        int n;
        int k;
        int count;
        int slot;
        int v;
        rst_n     = 1'b0;
        start     = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        calm      = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty and single-point tables: no segment, so no bracket.
        write_span(0);
        issue(query_req(0, 1'b1));
        write_span(1);
        issue(query_req($urandom, 1'b0));

        // Fill every slot with a rising ramp so that any count is safe to search.
        for (int i = 0; i < pli_pkg::POINTS; i++)
        begin
            issue(load_req(i, 32'sh8000_0000 + i * (1 << 22), $urandom));
            rest(gap_len());
        end
        write_span(pli_pkg::POINTS);
        issue(query_req(32'sh8000_0000, 1'b0));  // at the first point
        issue(query_req(32'sh7fff_ffff, 1'b1));  // above every point
        issue(query_req($urandom, 1'b0));
        write_span(2047);                         // clamped to the table size
        issue(query_req($urandom, 1'b1));

        // Saturating extremes and extrapolation below the first point.
        write_span(4);
        issue(load_req(0, 0, 32'sh7fff_ffff));
        issue(load_req(1, 32'h0001_0000, 32'sh8000_0000));
        issue(load_req(2, 32'h0002_0000, 0));
        issue(load_req(3, 32'sh7fff_ffff, 32'sh7fff_ffff));
        issue(query_req(32'sh8000_0000, 1'b0));
        issue(query_req(32'h0000_8000, 1'b0));
        issue(query_req(32'h0001_0000, 1'b1));
        issue(query_req(32'h4000_0000, 1'b0));

        // Equal leading abscissae give a zero-width segment; the table is unsorted.
        write_span(3);
        issue(load_req(0, 5 << 16, 100));
        issue(load_req(1, 5 << 16, -100));
        issue(load_req(2, -(3 << 16), 32'sh7fff_0000));
        issue(query_req(0, 1'b0));
        issue(query_req(6 << 16, 1'b1));
        issue(query_req(-(10 << 16), 1'b0));

        // Random phases, each under its own point count.
        count = 0;
        while (count < RANDOM_REQS)
        begin
            k = $urandom_range(0, 24);
            if (k == 0)
                n = 1024;
            else if (k == 1)
                n = 2047;
            else if (k == 2)
                n = $urandom_range(17, 1023);
            else if (k < 5)
                n = $urandom_range(0, 1);
            else
                n = $urandom_range(2, 16);
            write_span(n);
            calm = ($urandom_range(0, 3) == 0);
            if (n <= 16)
                load_table(n, count);
            else
                seg_x.delete();
            k = (n > 16) ? $urandom_range(1, 2) : $urandom_range(4, 20);
            for (int i = 0; i < k; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // Overwrite any slot; every slot already holds a point.
                    slot = $urandom_range(0, 1023);
                    v    = $urandom;
                    issue(load_req(slot, v, $urandom));
                    if (slot < seg_x.size())
                        seg_x[slot] = v;
                end
                else
                begin
                    issue(query_req(pick_query(), $urandom_range(0, 1)));
                end
                count++;
                if ($urandom_range(0, 30) == 0)
                    drain();
                else
                    rest(gap_len());
            end
        end

        drain();
        repeat (150) @(posedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire
